// ----- design/wbm_pkg.sv -----
package wbm_pkg;

    localparam int unsigned NumWin   = 8;
    localparam int unsigned DvdW     = 67;
    localparam int unsigned DvsW     = 39;
    localparam int unsigned RateW    = 31;
    localparam logic [RateW-1:0] RateMax = {RateW{1'b1}};

    // Milliseconds are taken as (elapsed_us / 8) * MsRecip >> MsShift, which is
    // exact for every 48-bit elapsed time.
    localparam int unsigned MsShift  = 52;
    localparam logic [47:0] MsRecip  = 48'd36028797018964;

    localparam logic [1:0] ModeAdd    = 2'd0;
    localparam logic [1:0] ModeSample = 2'd1;
    localparam logic [1:0] ModeReport = 2'd2;
    localparam logic [1:0] ModeUnused = 2'd3;

    typedef struct packed {
        logic [31:0] send_add;
        logic [31:0] recv_add;
        logic [47:0] now_us;
        logic [1:0]  mode;
    } t_item;

    function automatic logic [47:0] span_us(input logic [1:0] w);
        logic [47:0] s;
        case (w)
            2'd0:    s = 48'd30000000;
            2'd1:    s = 48'd60000000;
            2'd2:    s = 48'd300000000;
            default: s = 48'd3600000000;
        endcase
        return s;
    endfunction

endpackage

// ----- design/windowed_bitrate_meter_top.sv -----
// Channel  Direction  Signals                          Contents
// s_axis   in         i_s_axis_tvalid/tready/tdata/tuser  one input word
// m_axis   out        o_m_axis_tvalid/tready/tdata         one result word
//
// An add word updates the two totals and then gives its result.
// A sample or report word visits the eight windows in turn; a window whose
// span has elapsed adds a multiply for the milliseconds and a pass of the
// one-bit-per-cycle divider.
// Reset is synchronous and active low and clears all totals and windows.
// A short input queue keeps accepting words, until it is full, while the result waits.
module windowed_bitrate_meter_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // now_us[47:0], recv_add[79:48], send_add[111:80]
    input  logic [111:0] i_s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // recv_rate_30s, send_rate_30s, recv_rate_1m, send_rate_1m, recv_rate_5m,
    // send_rate_5m, recv_rate_60m, send_rate_60m (31 bits each from bit 0),
    // recv_delta[311:248], send_delta[375:312]
    output logic [375:0] o_m_axis_tdata
);

    wbm_pkg::t_item w_in_item;
    wbm_pkg::t_item w_q_item;
    logic           w_q_valid;
    logic           w_q_ready;

    assign w_in_item.mode     = i_s_axis_tuser;
    assign w_in_item.now_us   = i_s_axis_tdata[47:0];
    assign w_in_item.recv_add = i_s_axis_tdata[79:48];
    assign w_in_item.send_add = i_s_axis_tdata[111:80];

    wbm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_s_axis_tvalid),
        .o_wr_ready (o_s_axis_tready),
        .i_wr_item  (w_in_item),
        .o_rd_valid (w_q_valid),
        .i_rd_ready (w_q_ready),
        .o_rd_item  (w_q_item)
    );

    wbm_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_q_valid),
        .o_item_ready (w_q_ready),
        .i_item       (w_q_item),
        .o_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .o_res_data   (o_m_axis_tdata)
    );

endmodule

// ----- design/wbm_fifo.sv -----
module wbm_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  wbm_pkg::t_item i_wr_item,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output wbm_pkg::t_item o_rd_item
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    wbm_pkg::t_item r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            w_push;
    logic            w_pop;

    assign o_wr_ready = (r_count != CntW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_item  = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- design/wbm_div.sv -----
module wbm_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [wbm_pkg::DvdW-1:0]     i_dividend,
    input  logic [wbm_pkg::DvsW-1:0]     i_divisor,
    output logic                         o_done,
    output logic [wbm_pkg::DvdW-1:0]     o_quot
);

    localparam int unsigned CntW = $clog2(wbm_pkg::DvdW + 1);

    logic [CntW-1:0]           r_cnt;
    logic [wbm_pkg::DvsW-1:0]  r_rem;
    logic [wbm_pkg::DvdW-1:0]  r_q;
    logic [wbm_pkg::DvsW-1:0]  r_dvs;
    logic                      r_done;
    logic [wbm_pkg::DvsW:0]    w_rem2;
    logic                      w_ge;

    assign w_rem2 = {r_rem, r_q[wbm_pkg::DvdW-1]};
    assign w_ge   = (w_rem2 >= {1'b0, r_dvs});
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CntW'(wbm_pkg::DvdW);
                r_rem <= '0;
                r_q   <= i_dividend;
                r_dvs <= i_divisor;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (w_ge) begin
                    r_rem <= wbm_pkg::DvsW'(w_rem2 - {1'b0, r_dvs});
                end else begin
                    r_rem <= w_rem2[wbm_pkg::DvsW-1:0];
                end
                r_q <= {r_q[wbm_pkg::DvdW-2:0], w_ge};
                if (r_cnt == CntW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- design/wbm_core.sv -----
module wbm_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_valid,
    output logic                  o_item_ready,
    input  wbm_pkg::t_item        i_item,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic [375:0]          o_res_data
);

    localparam int unsigned AccW = wbm_pkg::MsShift + wbm_pkg::DvsW;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_MS, S_WAIT_RT, S_FIN, S_OUT
    } t_state;

    t_state                       r_state;
    wbm_pkg::t_item               r_item;
    logic [2:0]                   r_idx;
    logic [63:0]                  r_tot  [2];
    logic [63:0]                  r_mark [2];
    logic [63:0]                  r_wb   [wbm_pkg::NumWin];
    logic [47:0]                  r_wt   [wbm_pkg::NumWin];
    logic [wbm_pkg::RateW-1:0]    r_wr   [wbm_pkg::NumWin];
    logic [wbm_pkg::NumWin-1:0]   r_wv;
    logic [63:0]                  r_drecv;
    logic [63:0]                  r_dsend;
    logic                         r_start;
    logic [wbm_pkg::DvdW-1:0]     r_dvd;
    logic [wbm_pkg::DvsW-1:0]     r_dvs;
    logic [AccW-1:0]              r_acc;
    logic [AccW-1:0]              n_acc;
    logic [1:0]                   r_step;
    logic                         w_done;
    logic [wbm_pkg::DvdW-1:0]     w_quot;
    logic [63:0]                  w_total;
    logic [47:0]                  w_elapsed;
    logic [63:0]                  w_bytes;
    logic [44:0]                  w_y;
    logic [15:0]                  w_chunk;
    logic [60:0]                  w_prod;

    wbm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_done     (w_done),
        .o_quot     (w_quot)
    );

    assign o_item_ready = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_OUT);
    assign w_total      = r_tot[r_idx[2]];
    assign w_elapsed    = r_item.now_us - r_wt[r_idx];
    assign w_bytes      = w_total - r_wb[r_idx];
    assign w_y          = w_elapsed[47:3];
    assign w_prod       = {16'd0, w_y} * {45'd0, w_chunk};
    assign n_acc        = {r_acc[AccW-17:0], 16'd0} + AccW'(w_prod);

    always_comb begin
        case (r_step)
            2'd2:    w_chunk = wbm_pkg::MsRecip[47:32];
            2'd1:    w_chunk = wbm_pkg::MsRecip[31:16];
            default: w_chunk = wbm_pkg::MsRecip[15:0];
        endcase
    end

    always_comb begin
        for (int w = 0; w < 4; w++) begin
            o_res_data[62*w +: 31]      = r_wr[w];
            o_res_data[62*w + 31 +: 31] = r_wr[4 + w];
        end
        o_res_data[311:248] = r_drecv;
        o_res_data[375:312] = r_dsend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_start <= 1'b0;
            r_wv    <= '0;
            r_drecv <= '0;
            r_dsend <= '0;
            r_step  <= '0;
            for (int d = 0; d < 2; d++) begin
                r_tot[d]  <= '0;
                r_mark[d] <= '0;
            end
            for (int w = 0; w < wbm_pkg::NumWin; w++) begin
                r_wb[w] <= '0;
                r_wt[w] <= '0;
                r_wr[w] <= '0;
            end
        end else begin
            r_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_item <= i_item;
                        r_idx  <= '0;
                        if (i_item.mode == wbm_pkg::ModeAdd) begin
                            r_tot[0] <= r_tot[0] + 64'(i_item.recv_add);
                            r_tot[1] <= r_tot[1] + 64'(i_item.send_add);
                            r_state  <= S_FIN;
                        end else if (i_item.mode == wbm_pkg::ModeSample ||
                                     i_item.mode == wbm_pkg::ModeReport) begin
                            r_state <= S_CHECK;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_CHECK: begin
                    if (!r_wv[r_idx]) begin
                        r_wv[r_idx] <= 1'b1;
                        r_wb[r_idx] <= w_total;
                        r_wt[r_idx] <= r_item.now_us;
                        r_wr[r_idx] <= '0;
                        r_idx       <= r_idx + 1'b1;
                        r_state     <= (r_idx == 3'd7) ? S_FIN : S_CHECK;
                    end else if (r_item.now_us >= r_wt[r_idx] &&
                                 w_elapsed >= wbm_pkg::span_us(r_idx[1:0])) begin
                        r_acc   <= '0;
                        r_step  <= 2'd2;
                        r_state <= S_MS;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= (r_idx == 3'd7) ? S_FIN : S_CHECK;
                    end
                end
                S_MS: begin
                    r_acc <= n_acc;
                    if (r_step == 2'd0) begin
                        r_dvd   <= {w_bytes, 3'b000};
                        r_dvs   <= n_acc[AccW-1:wbm_pkg::MsShift];
                        r_start <= 1'b1;
                        r_state <= S_WAIT_RT;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_WAIT_RT: begin
                    if (w_done) begin
                        if (w_quot > wbm_pkg::DvdW'(wbm_pkg::RateMax)) begin
                            r_wr[r_idx] <= wbm_pkg::RateMax;
                        end else begin
                            r_wr[r_idx] <= w_quot[wbm_pkg::RateW-1:0];
                        end
                        r_wb[r_idx] <= w_total;
                        r_wt[r_idx] <= r_item.now_us;
                        r_idx       <= r_idx + 1'b1;
                        r_state     <= (r_idx == 3'd7) ? S_FIN : S_CHECK;
                    end
                end
                S_FIN: begin
                    if (r_item.mode == wbm_pkg::ModeReport) begin
                        r_drecv   <= r_tot[0] - r_mark[0];
                        r_dsend   <= r_tot[1] - r_mark[1];
                        r_mark[0] <= r_tot[0];
                        r_mark[1] <= r_tot[1];
                    end else begin
                        r_drecv <= '0;
                        r_dsend <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- tb/windowed_bitrate_meter_top_tb.sv -----
module windowed_bitrate_meter_top_tb;

    typedef struct {
        logic [30:0] rate [8];
        logic [63:0] recv_delta;
        logic [63:0] send_delta;
    } t_rates;

    class rate_scoreboard;
        logic [63:0] total [2];
        logic [63:0] mark [2];
        logic [63:0] win_bytes [8];
        logic [47:0] win_time [8];
        logic [30:0] win_rate [8];
        bit          win_started [8];
        string       rate_name [8];
        t_rates      pending [$];
        int          errors;

        function new();
            for (int i = 0; i < 2; i++) begin
                total[i] = '0;
                mark[i] = '0;
            end
            for (int i = 0; i < 8; i++) begin
                win_bytes[i] = '0;
                win_time[i] = '0;
                win_rate[i] = '0;
                win_started[i] = 0;
            end
            rate_name[0] = "recv_rate_30s";
            rate_name[1] = "send_rate_30s";
            rate_name[2] = "recv_rate_1m";
            rate_name[3] = "send_rate_1m";
            rate_name[4] = "recv_rate_5m";
            rate_name[5] = "send_rate_5m";
            rate_name[6] = "recv_rate_60m";
            rate_name[7] = "send_rate_60m";
            errors = 0;
        endfunction

        function logic [30:0] kbps(logic [63:0] bytes, logic [63:0] ms);
            logic [63:0] whole;
            logic [63:0] rest;
            logic [63:0] q;
            if (ms == 0) return '0;
            whole = bytes / ms;
            rest = bytes % ms;
            if (whole > 64'h0FFF_FFFF + 1) return wbm_pkg::RateMax;
            q = whole * 8 + (rest * 8) / ms;
            if (q > 64'h7FFF_FFFF) return wbm_pkg::RateMax;
            return q[30:0];
        endfunction

        function void note_word(logic [1:0] mode, logic [47:0] now,
                                logic [31:0] radd, logic [31:0] sadd);
            t_rates r;
            logic [63:0] tot;
            logic [63:0] span;
            r.recv_delta = '0;
            r.send_delta = '0;
            if (mode == wbm_pkg::ModeAdd) begin
                total[0] += {32'd0, radd};
                total[1] += {32'd0, sadd};
            end else if (mode == wbm_pkg::ModeSample || mode == wbm_pkg::ModeReport) begin
                for (int i = 0; i < 8; i++) begin
                    tot = total[i / 4];
                    span = {16'd0, wbm_pkg::span_us(2'(i % 4))};
                    if (!win_started[i]) begin
                        win_started[i] = 1;
                        win_bytes[i] = tot;
                        win_time[i] = now;
                        win_rate[i] = '0;
                    end
                    if (now >= win_time[i] && {16'd0, now - win_time[i]} >= span) begin
                        win_rate[i] = kbps(tot - win_bytes[i],
                                           {16'd0, now - win_time[i]} / 1000);
                        win_bytes[i] = tot;
                        win_time[i] = now;
                    end
                end
                if (mode == wbm_pkg::ModeReport) begin
                    r.recv_delta = total[0] - mark[0];
                    r.send_delta = total[1] - mark[1];
                    mark[0] = total[0];
                    mark[1] = total[1];
                end
            end
            for (int w = 0; w < 4; w++) begin
                r.rate[w * 2] = win_rate[w];
                r.rate[w * 2 + 1] = win_rate[4 + w];
            end
            pending.push_back(r);
        endfunction

        function void check_word(logic [375:0] d);
            t_rates e;
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int i = 0; i < 8; i++) begin
                if (d[i * 31 +: 31] !== e.rate[i]) begin
                    $error("%s: expected %0d, got %0d", rate_name[i], e.rate[i],
                           d[i * 31 +: 31]);
                    errors++;
                end
            end
            if (d[311:248] !== e.recv_delta) begin
                $error("recv_delta: expected %0d, got %0d", e.recv_delta, d[311:248]);
                errors++;
            end
            if (d[375:312] !== e.send_delta) begin
                $error("send_delta: expected %0d, got %0d", e.send_delta, d[375:312]);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [111:0] i_s_axis_tdata;
    logic [1:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [375:0] o_m_axis_tdata;

    rate_scoreboard sb;
    int   idle_cycles;
    bit   stall_on;
    logic [47:0] clock_us;

    windowed_bitrate_meter_top uut (.*);

    initial begin
        i_clk = 0;
    end

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_word(i_s_axis_tuser, i_s_axis_tdata[47:0],
                             i_s_axis_tdata[79:48], i_s_axis_tdata[111:80]);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_word(o_m_axis_tdata);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(negedge i_clk) begin
        if (idle_cycles > 20000) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : result_side
        int g;
        i_m_axis_tready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_on) begin
                g = gap_len();
                if (g > 0) begin
                    i_m_axis_tready <= 0;
                    repeat (g) @(negedge i_clk);
                end
            end
            i_m_axis_tready <= 1;
        end
    end

    task automatic send_word(logic [1:0] mode, logic [47:0] now,
                             logic [31:0] radd, logic [31:0] sadd);
        int g;
        g = stall_on ? gap_len() : 0;
        if (g > 0) begin
            i_s_axis_tvalid <= 0;
            repeat (g) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tuser <= mode;
        i_s_axis_tdata <= {sadd, radd, now};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_word();
        int k;
        logic [1:0] mode;
        logic [31:0] ra;
        logic [31:0] sa;
        k = $urandom_range(0, 99);
        if (k < 70) mode = wbm_pkg::ModeAdd;
        else if (k < 85) mode = wbm_pkg::ModeSample;
        else if (k < 97) mode = wbm_pkg::ModeReport;
        else mode = wbm_pkg::ModeUnused;
        case ($urandom_range(0, 3))
            0: clock_us = clock_us + 48'($urandom_range(0, 40000000));
            1: clock_us = clock_us + 48'({3'($urandom_range(0, 4)), 32'($urandom)});
            2: clock_us = clock_us + 48'($urandom_range(0, 2000));
            default: clock_us = clock_us - 48'($urandom_range(0, 70000000));
        endcase
        if ($urandom_range(0, 199) == 0) clock_us = {16'($urandom), 32'($urandom)};
        ra = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 100000);
        sa = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 100000);
        send_word(mode, clock_us, ra, sa);
    endtask

    initial begin
        sb = new();
        idle_cycles = 0;
        stall_on = 0;
        clock_us = '0;
        i_rst_n = 0;
        i_s_axis_tvalid = 0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = wbm_pkg::ModeAdd;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        send_word(wbm_pkg::ModeUnused, '1, '1, '1);
        send_word(wbm_pkg::ModeReport, 48'd0, '0, '0);
        send_word(wbm_pkg::ModeAdd, '0, '1, '1);
        send_word(wbm_pkg::ModeAdd, '1, '0, 32'd12345);
        send_word(wbm_pkg::ModeSample, 48'd29999999, '0, '0);
        send_word(wbm_pkg::ModeSample, 48'd30000000, '0, '0);
        send_word(wbm_pkg::ModeAdd, '0, '1, '1);
        send_word(wbm_pkg::ModeSample, 48'd31000000, '0, '0);
        send_word(wbm_pkg::ModeSample, 48'd5000, '0, '0);
        send_word(wbm_pkg::ModeReport, 48'd3600000000, '0, '0);
        for (int i = 0; i < 8; i++) send_word(wbm_pkg::ModeAdd, '0, '1, '1);
        send_word(wbm_pkg::ModeSample, 48'd3630000000, '0, '0);
        send_word(wbm_pkg::ModeSample, '1, '0, '0);
        send_word(wbm_pkg::ModeReport, '1, '1, '1);
        send_word(wbm_pkg::ModeUnused, '0, '0, '0);
        send_word(wbm_pkg::ModeAdd, 48'h5555_5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        clock_us = '1;
        for (int n = 0; n < 900; n++) begin
            stall_on = (n % 300) < 200;
            random_word();
        end
        i_s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (1200) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ----- files.f -----
design/wbm_pkg.sv
design/wbm_fifo.sv
design/wbm_div.sv
design/wbm_core.sv
design/windowed_bitrate_meter_top.sv
tb/windowed_bitrate_meter_top_tb.sv
